/* rtl/hr_pkg.sv */
// Shared types, constants and helpers for the histogram rebinner.
// Used by hr_edge_search, hr_sum_store and histogram_rebinner.
// No dependencies.
package hr_pkg;

    // Sizes of the input histogram and of the output bin set
    localparam int INPUT_BINS   = 120;
    localparam int MAX_OUT_BINS = 32;
    localparam int EDGE_DEPTH   = MAX_OUT_BINS + 1;

    // Field widths
    localparam int EDGE_W    = 16;
    localparam int CONTENT_W = 32;
    localparam int SUM_W     = 48;
    localparam int OUT_IDX_W = 5;

    // Derived widths
    localparam int POS_W       = $clog2(INPUT_BINS);
    localparam int EDGE_AW     = $clog2(EDGE_DEPTH);
    localparam int CNT_W       = $clog2(EDGE_DEPTH + 1);
    localparam int SUM_AW      = (MAX_OUT_BINS > 1) ? $clog2(MAX_OUT_BINS) : 1;
    localparam int LOWER_SHIFT = 8;

    // Saturation limits of a bin sum
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Opcodes
    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_CONTENT = 1'b1;

    typedef struct packed {
        logic                        opcode;
        logic [EDGE_W-1:0]           edge_value;
        logic signed [CONTENT_W-1:0] content;
    } hr_in_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]    bin_index;
        logic signed [SUM_W-1:0] bin_sum;
        logic                    error;
        logic                    last;
    } hr_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ACCUM,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_EMIT_ERR
    } hr_state_t;

    // Control from the sequencer to the edge table
    typedef struct packed {
        logic wr_req;
        logic advance;
        logic clear;
    } hr_edge_ctrl_t;

    // Status from the edge table to the sequencer
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [EDGE_AW-1:0] ptr;
        logic               in_range;
        logic               below;
        logic [SUM_AW-1:0]  target;
    } hr_edge_stat_t;

    // Control from the sequencer to the sum store
    typedef struct packed {
        logic              rd_en;
        logic [SUM_AW-1:0] rd_addr;
        logic              acc_en;
        logic [SUM_AW-1:0] acc_addr;
        logic              clear;
    } hr_sum_ctrl_t;

    // Lower edge of an input bin, in 1/256 of an input bin width
    function automatic logic [EDGE_W-1:0] lower_of(input logic [POS_W-1:0] pos);
        lower_of = EDGE_W'({pos, {LOWER_SHIFT{1'b0}}});
    endfunction

endpackage

/* rtl/hr_edge_search.sv */
// Edge table of the histogram rebinner: edge memory, fill count, first and
// last edge, and the forward-only search pointer. Depends on hr_pkg.
module hr_edge_search import hr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  hr_edge_ctrl_t     ctrl,
    input  logic [EDGE_W-1:0] edge_value,
    input  logic [EDGE_W-1:0] lower,
    output hr_edge_stat_t     stat
);

    logic [EDGE_W-1:0]  edge_mem [EDGE_DEPTH];
    logic [EDGE_W-1:0]  rd_edge_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [EDGE_AW-1:0] ptr_reg, ptr_next;
    logic [EDGE_W-1:0]  first_reg, first_next;
    logic [EDGE_W-1:0]  last_reg, last_next;
    logic               wr_en;
    logic               hit;

    // Append an edge while the table has room
    assign wr_en = ctrl.wr_req && (count_reg < CNT_W'(EDGE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        first_next = first_reg;
        last_next  = last_reg;
        ptr_next   = ptr_reg;
        if (wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
            last_next  = edge_value;
            if (count_reg == '0)
            begin
                first_next = edge_value;
            end
        end
        // Advance the pointer past edges below the current lower edge
        if (ctrl.advance)
        begin
            ptr_next = ptr_reg + EDGE_AW'(1);
        end
        if (ctrl.clear)
        begin
            count_next = '0;
            ptr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
    end

    // Edge memory: one write port, registered read at the next pointer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            edge_mem[count_reg[EDGE_AW-1:0]] <= edge_value;
        end
        rd_edge_reg <= edge_mem[ptr_next];
    end

    // Compare the edge under the pointer with the lower edge
    assign hit = (rd_edge_reg == lower);

    always_comb
    begin
        stat.count    = count_reg;
        stat.ptr      = ptr_reg;
        stat.in_range = (count_reg >= CNT_W'(2)) && (lower >= first_reg)
                        && (lower < last_reg);
        stat.below    = (rd_edge_reg < lower);
        stat.target   = hit ? SUM_AW'(ptr_reg) : SUM_AW'(ptr_reg - EDGE_AW'(1));
    end

endmodule

/* rtl/hr_sum_store.sv */
// Bin sum memory of the histogram rebinner with per-entry valid bits and
// the saturating accumulate. Depends on hr_pkg.
module hr_sum_store import hr_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hr_sum_ctrl_t                ctrl,
    input  logic signed [CONTENT_W-1:0] addend,
    output logic signed [SUM_W-1:0]     rd_sum
);

    logic [SUM_W-1:0]        sum_mem [MAX_OUT_BINS];
    logic [SUM_W-1:0]        rd_data_reg;
    logic                    rd_valid_reg;
    logic [MAX_OUT_BINS-1:0] valid_reg, valid_next;
    logic [SUM_W:0]          wide_sum;
    logic [SUM_W-1:0]        sat_sum;

    // An entry never written in this run reads as zero
    assign rd_sum = rd_valid_reg ? $signed(rd_data_reg) : '0;

    // Add with one guard bit, then clamp to the 48-bit range
    assign wide_sum = {rd_sum[SUM_W-1], rd_sum}
                      + {{(SUM_W+1-CONTENT_W){addend[CONTENT_W-1]}}, addend};

    always_comb
    begin
        if (wide_sum[SUM_W] != wide_sum[SUM_W-1])
        begin
            sat_sum = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sat_sum = wide_sum[SUM_W-1:0];
        end
    end

    // Mark written entries; drop all marks at the end of a run
    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.acc_en)
        begin
            valid_next[ctrl.acc_addr] = 1'b1;
        end
        if (ctrl.clear)
        begin
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctrl.rd_addr];
            end
        end
    end

    // Sum memory: write back the accumulated value, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en)
        begin
            sum_mem[ctrl.acc_addr] <= sat_sum;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= sum_mem[ctrl.rd_addr];
        end
    end

endmodule

/* rtl/histogram_rebinner.sv */
// Top level of the histogram rebinner: sequencer, result register and the
// edge table and sum store. Depends on hr_pkg, hr_edge_search, hr_sum_store.
//
// Load the output bin edges first (opcode 0, one edge per item, at most 33,
// ascending), then send the 120 input bin contents in bin order (opcode 1).
// A content inside the loaded edge range starts a search in which the
// search pointer passes every edge below the content's lower edge. The
// pointer only moves forward within a run. Each content inside the edge
// range is a read-modify-write of one sum in the sum memory. After the last
// content the block reports every output bin (memory read, then result
// register), or one error result when the edge table has under two entries;
// sums and edges are then cleared for the next run. Items are stalled while
// a content or the report is in progress. Edges sent after the first content
// of a run are ignored.
module histogram_rebinner import hr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  hr_in_t  item,
    output logic    result_valid,
    input  logic    result_stall,
    output hr_out_t result
);

    hr_state_t state_reg, state_next;

    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [EDGE_W-1:0]           lower_reg, lower_next;
    logic signed [CONTENT_W-1:0] content_reg, content_next;
    logic                        end_reg, end_next;
    logic [SUM_AW-1:0]           target_reg, target_next;
    logic [SUM_AW-1:0]           emit_idx_reg, emit_idx_next;
    logic                        out_valid_reg, out_valid_next;
    hr_out_t                     out_reg, out_next;

    hr_edge_ctrl_t          edge_ctrl;
    hr_edge_stat_t          edge_stat;
    hr_sum_ctrl_t           sum_ctrl;
    logic signed [SUM_W-1:0] rd_sum;
    logic [EDGE_W-1:0]      lower;
    logic                   item_fire;
    logic                   content_fire;
    logic                   end_now;
    logic                   slot_free;
    logic                   emit_last;
    logic                   run_end;

    assign item_fire    = item_valid && !item_stall;
    assign content_fire = item_fire && (item.opcode == OP_CONTENT);
    assign end_now      = (pos_reg == POS_W'(INPUT_BINS - 1));
    assign slot_free    = !out_valid_reg || !result_stall;
    assign emit_last    = ({1'b0, emit_idx_reg} == (edge_stat.count - CNT_W'(2)));
    assign lower        = (state_reg == ST_IDLE) ? lower_of(pos_reg) : lower_reg;

    hr_edge_search u_edge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (edge_ctrl),
        .edge_value (item.edge_value),
        .lower      (lower),
        .stat       (edge_stat)
    );

    hr_sum_store u_sum (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (sum_ctrl),
        .addend (content_reg),
        .rd_sum (rd_sum)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (content_fire)
                begin
                    if (edge_stat.in_range)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else if (end_now)
                    begin
                        state_next = (edge_stat.count < CNT_W'(2)) ? ST_EMIT_ERR
                                                                   : ST_EMIT_RD;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (!edge_stat.below)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                state_next = end_reg ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (slot_free)
                begin
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_EMIT_ERR:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer
    always_comb
    begin
        item_stall        = 1'b1;
        run_end           = 1'b0;
        edge_ctrl.wr_req  = 1'b0;
        edge_ctrl.advance = 1'b0;
        sum_ctrl.rd_en    = 1'b0;
        sum_ctrl.rd_addr  = edge_stat.target;
        sum_ctrl.acc_en   = 1'b0;
        sum_ctrl.acc_addr = target_reg;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall       = 1'b0;
                edge_ctrl.wr_req = item_valid && (item.opcode == OP_EDGE)
                                   && (pos_reg == '0);
            end
            ST_SEARCH:
            begin
                edge_ctrl.advance = edge_stat.below;
                sum_ctrl.rd_en    = !edge_stat.below;
            end
            ST_ACCUM:
            begin
                sum_ctrl.acc_en = 1'b1;
            end
            ST_EMIT_RD:
            begin
                sum_ctrl.rd_en   = 1'b1;
                sum_ctrl.rd_addr = emit_idx_reg;
            end
            ST_EMIT_WR:
            begin
                run_end = slot_free && emit_last;
            end
            ST_EMIT_ERR:
            begin
                run_end = slot_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
        edge_ctrl.clear = run_end;
        sum_ctrl.clear  = run_end;
    end

    // Datapath and result register next values
    always_comb
    begin
        pos_next       = pos_reg;
        lower_next     = lower_reg;
        content_next   = content_reg;
        end_next       = end_reg;
        target_next    = target_reg;
        emit_idx_next  = emit_idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        // Capture a content item and advance the input position
        if (content_fire)
        begin
            pos_next     = pos_reg + POS_W'(1);
            lower_next   = lower_of(pos_reg);
            content_next = item.content;
            end_next     = end_now;
        end
        // Hold the target bin for the write-back
        if ((state_reg == ST_SEARCH) && !edge_stat.below)
        begin
            target_next = edge_stat.target;
        end
        // Load one result into the output register
        if ((state_reg == ST_EMIT_WR) && slot_free)
        begin
            out_next.bin_index = OUT_IDX_W'(emit_idx_reg);
            out_next.bin_sum   = rd_sum;
            out_next.error     = 1'b0;
            out_next.last      = emit_last;
            out_valid_next     = 1'b1;
            emit_idx_next      = emit_idx_reg + SUM_AW'(1);
        end
        if ((state_reg == ST_EMIT_ERR) && slot_free)
        begin
            out_next.bin_index = '0;
            out_next.bin_sum   = '0;
            out_next.error     = 1'b1;
            out_next.last      = 1'b1;
            out_valid_next     = 1'b1;
        end
        // Rewind for the next run
        if (run_end)
        begin
            pos_next      = '0;
            emit_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            end_reg       <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            end_reg       <= end_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lower_reg   <= lower_next;
        content_reg <= content_next;
        target_reg  <= target_next;
        out_reg     <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // The search never runs past the last loaded edge
    a_search_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> ({1'b0, edge_stat.ptr} < (EDGE_AW+1)'(edge_stat.count)))
        else $error("edge search pointer beyond loaded edges");

    // A write-back targets a reported output bin
    a_accum_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCUM)
        |-> ((CNT_W+1)'(target_reg) < (CNT_W+1)'(edge_stat.count - CNT_W'(1))))
        else $error("sum write-back outside the output bins");

    // Bin reports happen only with at least two entries in the edge table
    a_emit_edges: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT_RD) || (state_reg == ST_EMIT_WR))
        |-> (edge_stat.count >= CNT_W'(2)))
        else $error("bin report without two edges");

    // The end of a run leaves the edge table empty and the input position at zero
    a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        run_end |=> ((edge_stat.count == '0) && (pos_reg == '0)))
        else $error("run end did not clear edges and position");

endmodule

/* tb/hr_rebin_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the histogram rebinner: watches the item and result channels,
// predicts the output bin sums and compares each result. Depends on hr_pkg.
module hr_rebin_checker import hr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  hr_in_t  item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  hr_out_t result,
    output int      mismatches,
    output int      expected_left
);

    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;

    // Shadow copy of the block's state
    logic [EDGE_W-1:0] bound_edge [EDGE_DEPTH];
    int                edge_cnt;
    int                in_pos;
    longint            bin_acc [MAX_OUT_BINS];
    hr_out_t           pending_q [$];
    hr_out_t           want;

    task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
        $display("mismatch on %s: got %0d, want %0d", what, got, exp_val);
        mismatches++;
    endtask

    // Pick the output bin of an input bin, or -1 when its content is dropped
    function automatic int target_bin(input int pos);
        int unsigned lower;
        int          k;
        lower = pos << LOWER_SHIFT;
        if (edge_cnt < 2)
            return -1;
        if (lower < bound_edge[0] || lower >= bound_edge[edge_cnt-1])
            return -1;
        k = 0;
        while (k < edge_cnt && bound_edge[k] < lower)
            k++;
        if (k >= edge_cnt)
            return -1;
        if (bound_edge[k] != lower)
        begin
            if (k == 0)
                return -1;
            k--;
        end
        if (k >= edge_cnt - 1 || k >= MAX_OUT_BINS)
            return -1;
        return k;
    endfunction

    // Apply one accepted item and queue the results it causes
    task automatic predict_rebin(input hr_in_t it);
        int      tgt;
        int      nb;
        longint  s;
        hr_out_t r;
        if (it.opcode == OP_EDGE)
        begin
            // drop edges once contents have started or the table is full
            if (in_pos == 0 && edge_cnt < EDGE_DEPTH)
            begin
                bound_edge[edge_cnt] = it.edge_value;
                edge_cnt++;
            end
        end
        else
        begin
            tgt = target_bin(in_pos);
            if (tgt >= 0)
            begin
                s = bin_acc[tgt] + longint'($signed(it.content));
                if (s > SUM_HI)
                    s = SUM_HI;
                if (s < SUM_LO)
                    s = SUM_LO;
                bin_acc[tgt] = s;
            end
            in_pos++;
            if (in_pos == INPUT_BINS)
            begin
                if (edge_cnt < 2)
                begin
                    r.bin_index = '0;
                    r.bin_sum   = '0;
                    r.error     = 1'b1;
                    r.last      = 1'b1;
                    pending_q.push_back(r);
                end
                else
                begin
                    nb = (edge_cnt - 1 > MAX_OUT_BINS) ? MAX_OUT_BINS : edge_cnt - 1;
                    for (int k = 0; k < nb; k++)
                    begin
                        r.bin_index = OUT_IDX_W'(k);
                        r.bin_sum   = SUM_W'(bin_acc[k]);
                        r.error     = 1'b0;
                        r.last      = (k + 1 == nb);
                        pending_q.push_back(r);
                    end
                end
                // clear for the next run
                for (int k = 0; k < MAX_OUT_BINS; k++)
                    bin_acc[k] = 0;
                in_pos   = 0;
                edge_cnt = 0;
            end
        end
    endtask

    // Compare accepted results, then predict from accepted items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_OUT_BINS; k++)
                bin_acc[k] = 0;
            edge_cnt      = 0;
            in_pos        = 0;
            mismatches    = 0;
            expected_left = 0;
            pending_q.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_q.size() == 0)
                    flag_mismatch("result with nothing pending, bin_index",
                                  result.bin_index, -1);
                else
                begin
                    want = pending_q.pop_front();
                    if (result.bin_index !== want.bin_index)
                        flag_mismatch("bin_index", result.bin_index, want.bin_index);
                    if (result.bin_sum !== want.bin_sum)
                        flag_mismatch("bin_sum", result.bin_sum, want.bin_sum);
                    if (result.error !== want.error)
                        flag_mismatch("error", result.error, want.error);
                    if (result.last !== want.last)
                        flag_mismatch("last", result.last, want.last);
                end
            end
            if (item_valid && !item_stall)
                predict_rebin(item);
            expected_left = pending_q.size();
        end
    end

endmodule

/* tb/tb_histogram_rebinner.sv */
`timescale 1ns / 1ps
// Testbench top for the histogram rebinner: clock, reset, item and result
// stimulus, and the verdict. Depends on hr_pkg and hr_rebin_checker.
module tb_histogram_rebinner;
    import hr_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    hr_in_t  item;
    logic    result_valid;
    logic    result_stall;
    hr_out_t result;

    int mismatches;
    int expected_left;
    int gap_pct;
    int cycle_cnt;
    bit quiet;
    bit long_hold;
    bit hold_taken;

    histogram_rebinner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    hr_rebin_checker rebin_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .mismatches    (mismatches),
        .expected_left (expected_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // End the run if it hangs
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    // Offer one item, idling first at random, and hold it until accepted
    task automatic send_item(input hr_in_t it);
        if (!quiet && $urandom_range(1, 100) <= gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Load a set of edges, then send one full histogram of contents
    task automatic run_pass(input int n_edges, input bit scramble, input bit aligned,
                            input bit mid_edges, input bit extremes, input bit hold_late);
        hr_in_t      it;
        int unsigned e;
        int unsigned stride;
        stride = (n_edges > 0) ? 62000 / n_edges : 1;
        e      = extremes ? 0 : $urandom_range(0, 1500);
        for (int i = 0; i < n_edges; i++)
        begin
            it.opcode  = OP_EDGE;
            it.content = $urandom;
            if (scramble)
                it.edge_value = EDGE_W'($urandom_range(0, 32767));
            else
            begin
                if (i > 0)
                    e = e + $urandom_range(1, stride);
                if (e > 65535)
                    e = 65535;
                it.edge_value = aligned ? EDGE_W'(e & 32'hFFFF_FF00) : EDGE_W'(e);
            end
            if (extremes && i == n_edges - 1)
                it.edge_value = '1;
            send_item(it);
        end
        for (int i = 0; i < INPUT_BINS; i++)
        begin
            // slip in an edge after the run has started; it must be ignored
            if (mid_edges && i > 0 && $urandom_range(0, 9) == 0)
            begin
                it.opcode     = OP_EDGE;
                it.edge_value = EDGE_W'($urandom);
                it.content    = $urandom;
                send_item(it);
            end
            if (hold_late && i == INPUT_BINS - 4)
                long_hold = 1'b1;
            it.opcode     = OP_CONTENT;
            it.edge_value = EDGE_W'($urandom);
            if (extremes)
            begin
                case ($urandom_range(0, 4))
                    0:       it.content = 32'h7FFF_FFFF;
                    1:       it.content = 32'h8000_0000;
                    2:       it.content = '0;
                    3:       it.content = '1;
                    default: it.content = $urandom;
                endcase
            end
            else
                it.content = $urandom;
            send_item(it);
        end
    endtask

    // Stall the result channel in bursts, calm stretches and one long hold
    initial
    begin
        int burst;
        int tick;
        burst        = 0;
        tick         = 0;
        result_stall = 1'b0;
        hold_taken   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            tick++;
            if (long_hold && !hold_taken)
            begin
                hold_taken = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_stall <= 1'b0;
            end
            else if (quiet || (burst == 0 && (tick / 128) % 3 == 2))
                result_stall <= 1'b0;
            else if (burst > 0)
            begin
                burst--;
                result_stall <= 1'b1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(0, 8);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Reset, directed runs, drain and verdict
    initial
    begin
        item_valid = 1'b0;
        item       = '0;
        rst_n      = 1'b0;
        quiet      = 1'b0;
        long_hold  = 1'b0;
        gap_pct    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // too many edges from 0 to the top, late edges, extreme contents,
        // and a long result hold over the report
        gap_pct = 20;
        run_pass(EDGE_DEPTH + 2, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        // no edges at all, late edges and extreme contents: one error result
        gap_pct = 10;
        run_pass(0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);

        // let the block drain completely, then finish with edges out of
        // order and no idling on either side
        wait (expected_left == 0);
        quiet   = 1'b1;
        gap_pct = 0;
        run_pass($urandom_range(2, 12), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        item_valid <= 1'b0;

        wait (expected_left == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_left == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
